// File: hdl/pps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Preemptive priority scheduler package
// Shared types and fixed field widths for the scheduler core and its store.
// ----------------------------------------------------------------------------
package pps_pkg;

    localparam int BURST_W    = 16;
    localparam int ARRIVAL_W  = 16;
    localparam int PRIO_W     = 8;
    localparam int TASK_NUM_W = 6;
    localparam int OUT_TIME_W = 21;

    localparam logic [OUT_TIME_W-1:0] TIME_MAX = {OUT_TIME_W{1'b1}};

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_STEP,
        ST_COMMIT,
        ST_REPORT
    } t_state;

    // Write enables of the task store.
    typedef struct packed {
        logic we_task;
        logic we_rem;
        logic we_comp;
    } t_mem_we;

endpackage : pps_pkg
`default_nettype wire

// File: hdl/pps_task_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Task store
// One write address and one read address per cycle; read data is registered.
// ----------------------------------------------------------------------------
module pps_task_mem #(
    parameter int DEPTH = 16,
    parameter int IW    = 4,
    parameter int TW    = 21
) (
    input  wire                          i_clk,
    input  wire pps_pkg::t_mem_we        i_we,
    input  wire [IW-1:0]                 i_waddr,
    input  wire [pps_pkg::BURST_W-1:0]   i_burst,
    input  wire [pps_pkg::ARRIVAL_W-1:0] i_arrival,
    input  wire [pps_pkg::PRIO_W-1:0]    i_prio,
    input  wire [pps_pkg::BURST_W-1:0]   i_rem,
    input  wire [TW-1:0]                 i_comp,
    input  wire [IW-1:0]                 i_raddr,
    output logic [pps_pkg::BURST_W-1:0]   o_burst,
    output logic [pps_pkg::ARRIVAL_W-1:0] o_arrival,
    output logic [pps_pkg::PRIO_W-1:0]    o_prio,
    output logic [pps_pkg::BURST_W-1:0]   o_rem,
    output logic [TW-1:0]                 o_comp
);

    logic [pps_pkg::BURST_W-1:0]   r_burst_mem   [DEPTH];
    logic [pps_pkg::ARRIVAL_W-1:0] r_arrival_mem [DEPTH];
    logic [pps_pkg::PRIO_W-1:0]    r_prio_mem    [DEPTH];
    logic [pps_pkg::BURST_W-1:0]   r_rem_mem     [DEPTH];
    logic [TW-1:0]                 r_comp_mem    [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we.we_task) begin
            r_burst_mem[i_waddr]   <= i_burst;
            r_arrival_mem[i_waddr] <= i_arrival;
            r_prio_mem[i_waddr]    <= i_prio;
        end
        if (i_we.we_task || i_we.we_rem) begin
            r_rem_mem[i_waddr] <= i_rem;
        end
        if (i_we.we_comp) begin
            r_comp_mem[i_waddr] <= i_comp;
        end
        o_burst   <= r_burst_mem[i_raddr];
        o_arrival <= r_arrival_mem[i_raddr];
        o_prio    <= r_prio_mem[i_raddr];
        o_rem     <= r_rem_mem[i_raddr];
        o_comp    <= r_comp_mem[i_raddr];
    end

endmodule : pps_task_mem
`default_nettype wire

// File: hdl/preemptive_priority_scheduler_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Preemptive priority scheduler core
// Loads a task set, simulates preemptive priority scheduling and reports the
// completion, turnaround and waiting time of every task in load order.
// ----------------------------------------------------------------------------
// Usage. A task is transferred at a rising edge with start high and busy low.
// While busy is low one task can be transferred in every cycle; tasks beyond
// MAX_TASKS are discarded. The transfer that carries i_last_task raises busy
// and starts the walk, even when the task itself was discarded.
// The walk is event driven: an event that runs a task (to its completion or
// to a preemption at an arrival) scans the stored tasks through the single
// read port of the task store, drains its registered read (ST_DRAIN), picks
// the run length (ST_STEP) and commits it (ST_COMMIT). An idle jump to the
// next arrival needs no commit.
// A set needs at most about 2N events.
// Reporting then reads one task per cycle; each report passes the registered
// store read and then the report registers, shows on o_strobe for exactly one
// cycle, and the final one carries o_last_result. The receiver cannot stall,
// so nothing is held back. busy falls as the last report is read, so a new
// set may start loading while the last two reports are still leaving.
// A synchronous reset returns the sequencer to idle with an empty set; the
// store contents are left as they are and are rewritten before use.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_core #(
    parameter int MAX_TASKS = 16
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           start,
    input  wire [pps_pkg::BURST_W-1:0]    i_burst_time,
    input  wire [pps_pkg::ARRIVAL_W-1:0]  i_arrival_time,
    input  wire [pps_pkg::PRIO_W-1:0]     i_priority_req,
    input  wire                           i_last_task,
    output logic                          busy,
    output logic                          o_strobe,
    output logic [pps_pkg::TASK_NUM_W-1:0] o_task_number,
    output logic [pps_pkg::OUT_TIME_W-1:0] o_finish_time,
    output logic [pps_pkg::OUT_TIME_W-1:0] o_turnaround,
    output logic [pps_pkg::OUT_TIME_W-1:0] o_wait_time,
    output logic                          o_last_result
);

    // Index and count widths; the count must also hold MAX_TASKS itself.
    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);
    // Simulated time never exceeds the latest arrival plus the sum of bursts,
    // which stays below 2^16 * (MAX_TASKS + 1).
    localparam int TW = pps_pkg::BURST_W + CW;
    // Width in which saturation to the report field is decided.
    localparam int SW = (TW > pps_pkg::OUT_TIME_W) ? TW : pps_pkg::OUT_TIME_W;

    localparam logic [SW-1:0] SAT_LIMIT = SW'(pps_pkg::TIME_MAX);

    // Control registers.
    pps_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_done, n_done;
    logic [TW-1:0]   r_time, n_time;
    logic [IW-1:0]   r_idx, n_idx;
    logic            r_scan_vld, n_scan_vld;
    logic            r_rep_vld, n_rep_vld;
    logic            r_have_best, n_have_best;
    logic            r_have_next, n_have_next;
    logic            r_strobe;

    // Walk and report payload registers.
    logic [IW-1:0]                 r_rd_idx, n_rd_idx;
    logic                          r_rep_last, n_rep_last;
    logic [IW-1:0]                 r_best, n_best;
    logic [pps_pkg::PRIO_W-1:0]    r_best_prio, n_best_prio;
    logic [pps_pkg::BURST_W-1:0]   r_best_rem, n_best_rem;
    logic [pps_pkg::ARRIVAL_W-1:0] r_next_arr, n_next_arr;
    logic [pps_pkg::BURST_W-1:0]   r_run, n_run;
    logic [pps_pkg::TASK_NUM_W-1:0] r_task_number;
    logic [pps_pkg::OUT_TIME_W-1:0] r_completion, r_turnaround, r_waiting;
    logic                          r_last_result;

    // Store interface.
    pps_pkg::t_mem_we              mem_we;
    logic [IW-1:0]                 mem_waddr;
    logic [pps_pkg::BURST_W-1:0]   mem_rem_wdata;
    logic [pps_pkg::BURST_W-1:0]   mem_burst;
    logic [pps_pkg::ARRIVAL_W-1:0] mem_arrival;
    logic [pps_pkg::PRIO_W-1:0]    mem_prio;
    logic [pps_pkg::BURST_W-1:0]   mem_rem;
    logic [TW-1:0]                 mem_comp;

    logic [pps_pkg::BURST_W-1:0]   burst_fixed;
    logic [TW-1:0]                 gap;
    logic [TW-1:0]                 time_after;
    logic [TW-1:0]                 turn_raw;
    logic [TW-1:0]                 wait_raw;

    pps_task_mem #(
        .DEPTH (MAX_TASKS),
        .IW    (IW),
        .TW    (TW)
    ) u_task_mem (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_burst   (burst_fixed),
        .i_arrival (i_arrival_time),
        .i_prio    (i_priority_req),
        .i_rem     (mem_rem_wdata),
        .i_comp    (time_after),
        .i_raddr   (r_idx),
        .o_burst   (mem_burst),
        .o_arrival (mem_arrival),
        .o_prio    (mem_prio),
        .o_rem     (mem_rem),
        .o_comp    (mem_comp)
    );

    // A task that asks for no service at all is treated as needing one unit.
    assign burst_fixed = (i_burst_time == '0) ? pps_pkg::BURST_W'(1) : i_burst_time;

    assign gap        = TW'(r_next_arr) - r_time;
    assign time_after = r_time + TW'(r_run);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pps_pkg::ST_IDLE;
            r_count     <= '0;
            r_done      <= '0;
            r_time      <= '0;
            r_idx       <= '0;
            r_scan_vld  <= 1'b0;
            r_rep_vld   <= 1'b0;
            r_have_best <= 1'b0;
            r_have_next <= 1'b0;
            r_strobe    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_done      <= n_done;
            r_time      <= n_time;
            r_idx       <= n_idx;
            r_scan_vld  <= n_scan_vld;
            r_rep_vld   <= n_rep_vld;
            r_have_best <= n_have_best;
            r_have_next <= n_have_next;
            r_strobe    <= r_rep_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx    <= n_rd_idx;
        r_rep_last  <= n_rep_last;
        r_best      <= n_best;
        r_best_prio <= n_best_prio;
        r_best_rem  <= n_best_rem;
        r_next_arr  <= n_next_arr;
        r_run       <= n_run;
    end

    // Sequencer: next state, store control and the scan compare unit.
    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_done        = r_done;
        n_time        = r_time;
        n_idx         = r_idx;
        n_scan_vld    = 1'b0;
        n_rep_vld     = 1'b0;
        n_have_best   = r_have_best;
        n_have_next   = r_have_next;
        n_rd_idx      = r_idx;
        n_rep_last    = (CW'(r_idx) + CW'(1)) == r_count;
        n_best        = r_best;
        n_best_prio   = r_best_prio;
        n_best_rem    = r_best_rem;
        n_next_arr    = r_next_arr;
        n_run         = r_run;
        mem_we        = '0;
        mem_waddr     = r_best;
        mem_rem_wdata = burst_fixed;

        // Fold the entry read in the previous cycle into the running choice:
        // the ready task with the smallest priority number (earliest index on
        // a tie) and the earliest arrival still to come.
        if (r_scan_vld && (mem_rem != '0)) begin
            if (TW'(mem_arrival) <= r_time) begin
                if (!r_have_best || (mem_prio < r_best_prio)) begin
                    n_have_best = 1'b1;
                    n_best      = r_rd_idx;
                    n_best_prio = mem_prio;
                    n_best_rem  = mem_rem;
                end
            end else if (!r_have_next || (mem_arrival < r_next_arr)) begin
                n_have_next = 1'b1;
                n_next_arr  = mem_arrival;
            end
        end

        unique case (r_state)
            pps_pkg::ST_IDLE: begin
                if (start) begin
                    if (r_count < CW'(MAX_TASKS)) begin
                        mem_we.we_task = 1'b1;
                        mem_waddr      = r_count[IW-1:0];
                        n_count        = r_count + CW'(1);
                    end
                    if (i_last_task) begin
                        n_state     = pps_pkg::ST_SCAN;
                        n_idx       = '0;
                        n_time      = '0;
                        n_done      = '0;
                        n_have_best = 1'b0;
                        n_have_next = 1'b0;
                    end
                end
            end
            pps_pkg::ST_SCAN: begin
                n_scan_vld = 1'b1;
                if ((CW'(r_idx) + CW'(1)) == r_count) begin
                    n_state = pps_pkg::ST_DRAIN;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            pps_pkg::ST_DRAIN: begin
                n_state = pps_pkg::ST_STEP;
            end
            pps_pkg::ST_STEP: begin
                if (!r_have_best) begin
                    // Nothing is ready: jump to the next arrival and rescan.
                    n_time      = TW'(r_next_arr);
                    n_state     = pps_pkg::ST_SCAN;
                    n_idx       = '0;
                    n_have_best = 1'b0;
                    n_have_next = 1'b0;
                end else begin
                    // Run until the task finishes or the next arrival,
                    // whichever comes first.
                    if (r_have_next && (gap < TW'(r_best_rem))) begin
                        n_run = gap[pps_pkg::BURST_W-1:0];
                    end else begin
                        n_run = r_best_rem;
                    end
                    n_state = pps_pkg::ST_COMMIT;
                end
            end
            pps_pkg::ST_COMMIT: begin
                n_time        = time_after;
                mem_we.we_rem = 1'b1;
                mem_rem_wdata = r_best_rem - r_run;
                n_idx         = '0;
                n_have_best   = 1'b0;
                n_have_next   = 1'b0;
                n_state       = pps_pkg::ST_SCAN;
                if (r_run == r_best_rem) begin
                    mem_we.we_comp = 1'b1;
                    n_done         = r_done + CW'(1);
                    if ((r_done + CW'(1)) == r_count) begin
                        n_state = pps_pkg::ST_REPORT;
                    end
                end
            end
            pps_pkg::ST_REPORT: begin
                n_rep_vld = 1'b1;
                if ((CW'(r_idx) + CW'(1)) == r_count) begin
                    n_state = pps_pkg::ST_IDLE;
                    n_count = '0;
                    n_time  = '0;
                    n_done  = '0;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            default: begin
                n_state = pps_pkg::ST_IDLE;
            end
        endcase
    end

    // Report stage: derive the times from the registered store read and
    // clamp each one to the width of the report fields.
    assign turn_raw = mem_comp - TW'(mem_arrival);
    assign wait_raw = turn_raw - TW'(mem_burst);

    always_ff @(posedge i_clk) begin
        if (r_rep_vld) begin
            r_task_number <= pps_pkg::TASK_NUM_W'(r_rd_idx);
            r_completion  <= (SW'(mem_comp) > SAT_LIMIT) ? pps_pkg::TIME_MAX
                                                          : pps_pkg::OUT_TIME_W'(mem_comp);
            r_turnaround  <= (SW'(turn_raw) > SAT_LIMIT) ? pps_pkg::TIME_MAX
                                                          : pps_pkg::OUT_TIME_W'(turn_raw);
            r_waiting     <= (SW'(wait_raw) > SAT_LIMIT) ? pps_pkg::TIME_MAX
                                                          : pps_pkg::OUT_TIME_W'(wait_raw);
            r_last_result <= r_rep_last;
        end
    end

    assign busy          = (r_state != pps_pkg::ST_IDLE);
    assign o_strobe      = r_strobe;
    assign o_task_number = r_task_number;
    assign o_finish_time = r_completion;
    assign o_turnaround  = r_turnaround;
    assign o_wait_time   = r_waiting;
    assign o_last_result = r_last_result;

endmodule : preemptive_priority_scheduler_core
`default_nettype wire
